// ===== src/dpas_pkg.sv =====
// Shared types and constants for the data-processing ALU and shifter pipeline.
package dpas_pkg;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } dpas_op_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } dpas_shift_t;

    localparam int unsigned WordWidth = 32;
    localparam logic [7:0] FullShift = 8'd32;

    typedef struct packed {
        logic [3:0]  func;
        logic        set_flags;
        logic        use_immediate;
        logic [7:0]  imm_byte;
        logic [3:0]  rotate_half;
        logic [2:0]  shift_kind;
        logic [4:0]  shift_count;
        logic [31:0] first_operand;
        logic [31:0] second_operand;
        logic [7:0]  shift_register;
        logic [3:0]  flags_in;
        logic        dest_is_pc;
    } dpas_cmd_t;

    typedef struct packed {
        dpas_op_t    func;
        logic        set_flags;
        logic        dest_is_pc;
        logic [3:0]  flags_in;
        logic [31:0] a;
        logic [31:0] b;
        logic        shift_carry;
    } dpas_opnd_t;

    typedef struct packed {
        logic        set_flags;
        logic        dest_is_pc;
        logic        is_test;
        logic [3:0]  flags_in;
        logic [31:0] value;
        logic        carry;
        logic        overflow;
    } dpas_alu_t;

    typedef struct packed {
        logic [31:0] result;
        logic        write_result;
        logic [3:0]  flags_new;
        logic        flags_written;
        logic        restore_status;
    } dpas_rsp_t;

endpackage

// ===== src/dpas_ifs.sv =====
// Channel interfaces for commands, results and the configuration write port.
interface dpas_cmd_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic        set_flags;
    logic        use_immediate;
    logic [7:0]  imm_byte;
    logic [3:0]  rotate_half;
    logic [2:0]  shift_kind;
    logic [4:0]  shift_count;
    logic [31:0] first_operand;
    logic [31:0] second_operand;
    logic [7:0]  shift_register;
    logic [3:0]  flags_in;
    logic        dest_is_pc;

    modport source (
        output valid, func, set_flags, use_immediate, imm_byte, rotate_half, shift_kind,
               shift_count, first_operand, second_operand, shift_register, flags_in,
               dest_is_pc,
        input  ready
    );
    modport sink (
        input  valid, func, set_flags, use_immediate, imm_byte, rotate_half, shift_kind,
               shift_count, first_operand, second_operand, shift_register, flags_in,
               dest_is_pc,
        output ready
    );
endinterface

interface dpas_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic        write_result;
    logic [3:0]  flags_new;
    logic        flags_written;
    logic        restore_status;

    modport source (
        output valid, result, write_result, flags_new, flags_written, restore_status,
        input  ready
    );
    modport sink (
        input  valid, result, write_result, flags_new, flags_written, restore_status,
        output ready
    );
endinterface

interface dpas_cfg_if;
    logic valid;
    logic ready;
    logic core_variant;

    modport source (
        output valid, core_variant,
        input  ready
    );
    modport sink (
        input  valid, core_variant,
        output ready
    );
endinterface

// ===== src/data_processing_alu_shifter.sv =====
// Top level of the data-processing ALU with barrel shifter.
//
//   Channel  Direction  Transfer carries
//   cmd      in         one data-processing instruction with its operands and flags
//   rsp      out        result, write-back strobe, new flags and status-restore request
//   cfg      in         core_variant register value
//
// Three register stages (shifter, ALU, flags) lie between cmd and rsp.
// One instruction is taken every cycle while the result side keeps up.
// A stall on rsp holds every stage in place; bubbles are filled as they drain.
// Reset clears the stage valid bits and sets core_variant to zero.
module data_processing_alu_shifter
    import dpas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dpas_cmd_if.sink   cmd,
    dpas_rsp_if.source rsp,
    dpas_cfg_if.sink   cfg
);

    logic       core_variant_reg;
    logic       core_variant_next;
    dpas_cmd_t  cmd_word;
    dpas_opnd_t opnd;
    dpas_alu_t  alu;
    dpas_rsp_t  rsp_word;
    logic       s1_valid;
    logic       s1_ready;
    logic       s2_valid;
    logic       s2_ready;

    assign cfg.ready         = 1'b1;
    assign core_variant_next = cfg.valid ? cfg.core_variant : core_variant_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_variant_reg <= 1'b0;
        end
        else
        begin
            core_variant_reg <= core_variant_next;
        end
    end

    assign cmd_word.func           = cmd.func;
    assign cmd_word.set_flags      = cmd.set_flags;
    assign cmd_word.use_immediate  = cmd.use_immediate;
    assign cmd_word.imm_byte       = cmd.imm_byte;
    assign cmd_word.rotate_half    = cmd.rotate_half;
    assign cmd_word.shift_kind     = cmd.shift_kind;
    assign cmd_word.shift_count    = cmd.shift_count;
    assign cmd_word.first_operand  = cmd.first_operand;
    assign cmd_word.second_operand = cmd.second_operand;
    assign cmd_word.shift_register = cmd.shift_register;
    assign cmd_word.flags_in       = cmd.flags_in;
    assign cmd_word.dest_is_pc     = cmd.dest_is_pc;

    dpas_shift u_shift (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .cmd       (cmd_word),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .opnd      (opnd)
    );

    dpas_alu u_alu (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .opnd      (opnd),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .alu       (alu)
    );

    dpas_flags u_flags (
        .clk          (clk),
        .rst_n        (rst_n),
        .core_variant (core_variant_reg),
        .in_valid     (s2_valid),
        .in_ready     (s2_ready),
        .alu          (alu),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .rsp          (rsp_word)
    );

    assign rsp.result         = rsp_word.result;
    assign rsp.write_result   = rsp_word.write_result;
    assign rsp.flags_new      = rsp_word.flags_new;
    assign rsp.flags_written  = rsp_word.flags_written;
    assign rsp.restore_status = rsp_word.restore_status;

endmodule

// ===== src/dpas_shift.sv =====
// First pipeline stage: operand decode and barrel shifter.
module dpas_shift
    import dpas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dpas_cmd_t  cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output dpas_opnd_t opnd
);

    logic       valid_reg;
    logic       valid_next;
    dpas_opnd_t opnd_reg;
    dpas_opnd_t opnd_next;

    always_comb
    begin
        logic        cin;
        logic        by_reg;
        dpas_shift_t kind;
        logic [31:0] m;
        logic [7:0]  amt;
        logic [4:0]  amt5;
        logic        big;
        logic        eq32;
        logic [63:0] rot64;
        logic [63:0] imm64;
        logic [4:0]  up_idx;
        logic [4:0]  dn_idx;
        logic [31:0] sh_val;
        logic        sh_carry;
        logic [31:0] b;
        logic        sc;

        cin    = cmd.flags_in[1];
        by_reg = cmd.shift_kind[0];
        kind   = dpas_shift_t'(cmd.shift_kind[2:1]);
        m      = cmd.second_operand;

        if (by_reg)
        begin
            amt = cmd.shift_register;
        end
        else if (cmd.shift_count == 5'd0 && (kind == SH_LSR || kind == SH_ASR))
        begin
            amt = FullShift;
        end
        else
        begin
            amt = {3'b000, cmd.shift_count};
        end

        amt5   = amt[4:0];
        big    = (amt[7:5] != 3'b000);
        eq32   = (amt == FullShift);
        rot64  = {m, m} >> amt5;
        up_idx = 5'(6'd32 - {1'b0, amt5});
        dn_idx = amt5 - 5'd1;

        case (kind)
            SH_LSL:
            begin
                sh_val   = big ? '0 : (m << amt5);
                sh_carry = big ? (eq32 & m[0]) : m[up_idx];
            end
            SH_LSR:
            begin
                sh_val   = big ? '0 : (m >> amt5);
                sh_carry = big ? (eq32 & m[31]) : m[dn_idx];
            end
            SH_ASR:
            begin
                sh_val   = big ? {WordWidth{m[31]}} : 32'($signed(m) >>> amt5);
                sh_carry = big ? m[31] : m[dn_idx];
            end
            SH_ROR:
            begin
                sh_val   = (amt5 == 5'd0) ? m : rot64[31:0];
                sh_carry = (amt5 == 5'd0) ? m[31] : m[dn_idx];
            end
            default:
            begin
                sh_val   = m;
                sh_carry = cin;
            end
        endcase

        if (amt == 8'd0)
        begin
            if (!by_reg && kind == SH_ROR)
            begin
                sh_val   = {cin, m[31:1]};
                sh_carry = m[0];
            end
            else
            begin
                sh_val   = m;
                sh_carry = cin;
            end
        end

        imm64 = {24'd0, cmd.imm_byte, 24'd0, cmd.imm_byte} >> {cmd.rotate_half, 1'b0};

        if (cmd.use_immediate)
        begin
            b  = imm64[31:0];
            sc = (cmd.rotate_half == 4'd0) ? cin : imm64[31];
        end
        else
        begin
            b  = sh_val;
            sc = sh_carry;
        end

        opnd_next.func        = dpas_op_t'(cmd.func);
        opnd_next.set_flags   = cmd.set_flags;
        opnd_next.dest_is_pc  = cmd.dest_is_pc;
        opnd_next.flags_in    = cmd.flags_in;
        opnd_next.a           = cmd.first_operand;
        opnd_next.b           = b;
        opnd_next.shift_carry = sc;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            opnd_reg <= opnd_next;
        end
    end

    assign out_valid = valid_reg;
    assign opnd      = opnd_reg;

endmodule

// ===== src/dpas_alu.sv =====
// Second pipeline stage: logical and add/subtract operations with carry and overflow.
module dpas_alu
    import dpas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dpas_opnd_t opnd,
    output logic       out_valid,
    input  logic       out_ready,
    output dpas_alu_t  alu
);

    logic      valid_reg;
    logic      valid_next;
    dpas_alu_t alu_reg;
    dpas_alu_t alu_next;

    always_comb
    begin
        logic        cin;
        logic [31:0] x;
        logic [31:0] y;
        logic        c;
        logic        arith;
        logic [32:0] sum;
        logic [31:0] r;
        logic        cf;
        logic        vf;

        cin   = opnd.flags_in[1];
        x     = opnd.a;
        y     = opnd.b;
        c     = 1'b0;
        arith = 1'b1;

        case (opnd.func)
            OP_SUB, OP_CMP:
            begin
                y = ~opnd.b;
                c = 1'b1;
            end
            OP_RSB:
            begin
                x = opnd.b;
                y = ~opnd.a;
                c = 1'b1;
            end
            OP_ADD, OP_CMN:
            begin
                c = 1'b0;
            end
            OP_ADC:
            begin
                c = cin;
            end
            OP_SBC:
            begin
                y = ~opnd.b;
                c = cin;
            end
            OP_RSC:
            begin
                x = opnd.b;
                y = ~opnd.a;
                c = cin;
            end
            default:
            begin
                arith = 1'b0;
            end
        endcase

        sum = {1'b0, x} + {1'b0, y} + {32'd0, c};

        case (opnd.func)
            OP_AND, OP_TST: r = opnd.a & opnd.b;
            OP_EOR, OP_TEQ: r = opnd.a ^ opnd.b;
            OP_ORR:         r = opnd.a | opnd.b;
            OP_MOV:         r = opnd.b;
            OP_BIC:         r = opnd.a & ~opnd.b;
            OP_MVN:         r = ~opnd.b;
            default:        r = sum[31:0];
        endcase

        if (arith)
        begin
            cf = sum[32];
            vf = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);
        end
        else
        begin
            cf = opnd.shift_carry;
            vf = opnd.flags_in[0];
        end

        alu_next.set_flags  = opnd.set_flags;
        alu_next.dest_is_pc = opnd.dest_is_pc;
        alu_next.is_test    = (opnd.func == OP_TST) || (opnd.func == OP_TEQ)
                              || (opnd.func == OP_CMP) || (opnd.func == OP_CMN);
        alu_next.flags_in   = opnd.flags_in;
        alu_next.value      = r;
        alu_next.carry      = cf;
        alu_next.overflow   = vf;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            alu_reg <= alu_next;
        end
    end

    assign out_valid = valid_reg;
    assign alu       = alu_reg;

endmodule

// ===== src/dpas_flags.sv =====
// Third pipeline stage: flag generation, write-back decision and output register.
module dpas_flags
    import dpas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      core_variant,
    input  logic      in_valid,
    output logic      in_ready,
    input  dpas_alu_t alu,
    output logic      out_valid,
    input  logic      out_ready,
    output dpas_rsp_t rsp
);

    logic      valid_reg;
    logic      valid_next;
    dpas_rsp_t rsp_reg;
    dpas_rsp_t rsp_next;

    always_comb
    begin
        rsp_next.result         = alu.value;
        rsp_next.write_result   = !alu.is_test;
        rsp_next.flags_new      = alu.flags_in;
        rsp_next.flags_written  = 1'b0;
        rsp_next.restore_status = 1'b0;

        if (alu.set_flags)
        begin
            if (alu.dest_is_pc)
            begin
                if (core_variant && alu.is_test)
                begin
                    rsp_next.write_result = 1'b1;
                end
                else
                begin
                    rsp_next.restore_status = 1'b1;
                end
            end
            else
            begin
                rsp_next.flags_new     = {alu.value[31], (alu.value == 32'd0),
                                          alu.carry, alu.overflow};
                rsp_next.flags_written = 1'b1;
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule
